// ===== src/owbm_pkg.sv =====
package owbm_pkg;

   localparam int CFG_WIDTH           = 10;
   localparam int NUM_CFG             = 8;
   localparam int CFG_INDEX_WIDTH     = 3;
   localparam int COUNT_WIDTH_DEFAULT = 10;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_RESET = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   localparam logic [CFG_INDEX_WIDTH-1:0] REG_RESET_LOW     = 3'd0;
   localparam logic [CFG_INDEX_WIDTH-1:0] REG_PRESENCE_WAIT = 3'd1;
   localparam logic [CFG_INDEX_WIDTH-1:0] REG_RESET_RECOVER = 3'd2;
   localparam logic [CFG_INDEX_WIDTH-1:0] REG_WRITE_GAP     = 3'd3;
   localparam logic [CFG_INDEX_WIDTH-1:0] REG_WRITE_LOW     = 3'd4;
   localparam logic [CFG_INDEX_WIDTH-1:0] REG_WRITE_SLOT    = 3'd5;
   localparam logic [CFG_INDEX_WIDTH-1:0] REG_READ_SAMPLE   = 3'd6;
   localparam logic [CFG_INDEX_WIDTH-1:0] REG_READ_TAIL     = 3'd7;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'd0,
      PH_RLOW   = 4'd1,
      PH_RWAIT  = 4'd2,
      PH_RSAMP  = 4'd3,
      PH_RREC   = 4'd4,
      PH_WGAP   = 4'd5,
      PH_WLOW   = 4'd6,
      PH_WDATA  = 4'd7,
      PH_DLEAD  = 4'd8,
      PH_DIDLE  = 4'd9,
      PH_DPULSE = 4'd10,
      PH_DWAIT  = 4'd11,
      PH_DSAMP  = 4'd12,
      PH_DTAIL  = 4'd13
   } phase_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] reset_low_ticks;
      logic [CFG_WIDTH-1:0] presence_wait_ticks;
      logic [CFG_WIDTH-1:0] reset_recovery_ticks;
      logic [CFG_WIDTH-1:0] write_gap_ticks;
      logic [CFG_WIDTH-1:0] write_low_ticks;
      logic [CFG_WIDTH-1:0] write_slot_ticks;
      logic [CFG_WIDTH-1:0] read_sample_ticks;
      logic [CFG_WIDTH-1:0] read_tail_ticks;
   } cfg_type;

   localparam cfg_type CFG_DEFAULT = '{
      reset_low_ticks:      10'd500,
      presence_wait_ticks:  10'd30,
      reset_recovery_ticks: 10'd200,
      write_gap_ticks:      10'd100,
      write_low_ticks:      10'd2,
      write_slot_ticks:     10'd60,
      read_sample_ticks:    10'd5,
      read_tail_ticks:      10'd56
   };

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] data_byte;
      logic       bus_level;
   } req_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       no_presence;
   } rsp_type;

endpackage

// ===== src/owbm_engine.sv =====
module owbm_engine #(
   parameter int COUNT_WIDTH = owbm_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  owbm_pkg::req_type req,
   input  owbm_pkg::cfg_type cfg,
   output owbm_pkg::rsp_type rsp
);

   localparam int MASK_WIDTH = (COUNT_WIDTH > owbm_pkg::CFG_WIDTH) ?
                               owbm_pkg::CFG_WIDTH : COUNT_WIDTH;

   owbm_pkg::phase_type phase_ff, phase_in, cur_phase, nxt_phase;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in, cnt_cur, cnt_inc, len_raw, len;
   logic [2:0] bit_ff, bit_in, bit_cur;
   logic [7:0] shift_ff, shift_in, shift_cur;
   logic [7:0] rdata_ff, rdata_in;
   logic       pres_ff, pres_in;
   logic [owbm_pkg::CFG_WIDTH-1:0] sel_raw;
   logic [owbm_pkg::CFG_WIDTH+COUNT_WIDTH-1:0] sel_ext;
   logic       may_skip;
   logic       drive, busy, done;

   // length of the running phase, masked to the counter width
   always_comb begin
      sel_raw  = '0;
      may_skip = 1'b0;
      case (cur_phase)
         owbm_pkg::PH_RLOW:  sel_raw = cfg.reset_low_ticks;
         owbm_pkg::PH_RWAIT: sel_raw = cfg.presence_wait_ticks;
         owbm_pkg::PH_RREC: begin
            sel_raw  = cfg.reset_recovery_ticks;
            may_skip = 1'b1;
         end
         owbm_pkg::PH_WGAP: begin
            sel_raw  = cfg.write_gap_ticks;
            may_skip = 1'b1;
         end
         owbm_pkg::PH_WLOW:  sel_raw = cfg.write_low_ticks;
         owbm_pkg::PH_WDATA: sel_raw = cfg.write_slot_ticks;
         owbm_pkg::PH_DWAIT: sel_raw = cfg.read_sample_ticks;
         owbm_pkg::PH_DTAIL: begin
            sel_raw  = cfg.read_tail_ticks;
            may_skip = 1'b1;
         end
         default: sel_raw = '0;
      endcase
      sel_ext = {{COUNT_WIDTH{1'b0}}, sel_raw};
      len_raw = sel_ext[COUNT_WIDTH-1:0];
      len     = (len_raw == '0 && !may_skip) ? COUNT_WIDTH'(1) : len_raw;
   end

   always_comb begin
      cur_phase = phase_ff;
      cnt_cur   = cnt_ff;
      bit_cur   = bit_ff;
      shift_cur = shift_ff;
      pres_in   = pres_ff;
      rdata_in  = rdata_ff;
      drive     = 1'b0;
      busy      = 1'b0;
      done      = 1'b0;
      nxt_phase = owbm_pkg::PH_IDLE;

      // command start, ignored while busy
      if (phase_ff == owbm_pkg::PH_IDLE && req.op != owbm_pkg::OP_TICK) begin
         bit_cur = '0;
         cnt_cur = '0;
         case (req.op)
            owbm_pkg::OP_RESET: cur_phase = owbm_pkg::PH_RLOW;
            owbm_pkg::OP_WRITE: begin
               shift_cur = req.data_byte;
               cur_phase = (cfg.write_gap_ticks[MASK_WIDTH-1:0] == '0) ?
                           owbm_pkg::PH_WLOW : owbm_pkg::PH_WGAP;
            end
            owbm_pkg::OP_READ: begin
               shift_cur = '0;
               cur_phase = owbm_pkg::PH_DLEAD;
            end
            default: cur_phase = phase_ff;
         endcase
      end

      cnt_inc = cnt_cur + COUNT_WIDTH'(1);

      if (cur_phase != owbm_pkg::PH_IDLE) begin
         busy = 1'b1;
         case (cur_phase)
            owbm_pkg::PH_RLOW, owbm_pkg::PH_WLOW, owbm_pkg::PH_DPULSE: drive = 1'b1;
            owbm_pkg::PH_WDATA: drive = ~shift_cur[0];
            owbm_pkg::PH_RSAMP: pres_in = req.bus_level;
            owbm_pkg::PH_DSAMP: shift_cur = {req.bus_level, shift_cur[7:1]};
            default: drive = 1'b0;
         endcase
      end

      phase_in = cur_phase;
      cnt_in   = cnt_inc;
      bit_in   = bit_cur;
      shift_in = shift_cur;

      if (cur_phase != owbm_pkg::PH_IDLE && (cnt_inc == '0 || cnt_inc >= len)) begin
         cnt_in = '0;
         case (cur_phase)
            owbm_pkg::PH_RLOW:  nxt_phase = owbm_pkg::PH_RWAIT;
            owbm_pkg::PH_RWAIT: nxt_phase = owbm_pkg::PH_RSAMP;
            owbm_pkg::PH_RSAMP:
               nxt_phase = (pres_in || cfg.reset_recovery_ticks[MASK_WIDTH-1:0] == '0) ?
                           owbm_pkg::PH_IDLE : owbm_pkg::PH_RREC;
            owbm_pkg::PH_WGAP:  nxt_phase = owbm_pkg::PH_WLOW;
            owbm_pkg::PH_WLOW:  nxt_phase = owbm_pkg::PH_WDATA;
            owbm_pkg::PH_WDATA: begin
               shift_in  = {1'b0, shift_cur[7:1]};
               bit_in    = bit_cur + 3'd1;
               nxt_phase = (bit_in == '0) ? owbm_pkg::PH_IDLE : owbm_pkg::PH_WLOW;
            end
            owbm_pkg::PH_DLEAD:  nxt_phase = owbm_pkg::PH_DIDLE;
            owbm_pkg::PH_DIDLE:  nxt_phase = owbm_pkg::PH_DPULSE;
            owbm_pkg::PH_DPULSE: nxt_phase = owbm_pkg::PH_DWAIT;
            owbm_pkg::PH_DWAIT:  nxt_phase = owbm_pkg::PH_DSAMP;
            owbm_pkg::PH_DSAMP, owbm_pkg::PH_DTAIL: begin
               // zero tail finishes the bit on the sample tick
               if (cur_phase == owbm_pkg::PH_DSAMP &&
                   cfg.read_tail_ticks[MASK_WIDTH-1:0] != '0) begin
                  nxt_phase = owbm_pkg::PH_DTAIL;
               end else begin
                  bit_in = bit_cur + 3'd1;
                  if (bit_in == '0) begin
                     rdata_in  = shift_cur;
                     nxt_phase = owbm_pkg::PH_IDLE;
                  end else begin
                     nxt_phase = owbm_pkg::PH_DIDLE;
                  end
               end
            end
            default: nxt_phase = owbm_pkg::PH_IDLE;
         endcase
         phase_in = nxt_phase;
         done     = (nxt_phase == owbm_pkg::PH_IDLE);
      end else if (cur_phase == owbm_pkg::PH_IDLE) begin
         cnt_in = cnt_cur;
      end

      rsp.drive_low   = drive;
      rsp.busy_res    = busy;
      rsp.done_res    = done;
      rsp.read_data   = rdata_in;
      rsp.no_presence = pres_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= owbm_pkg::PH_IDLE;
         cnt_ff   <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
         rdata_ff <= '0;
         pres_ff  <= 1'b0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         rdata_ff <= rdata_in;
         pres_ff  <= pres_in;
      end
   end

endmodule

// ===== src/one_wire_bus_master.sv =====
// one-wire bus master, timed in microsecond ticks
//
// request channel: req_valid/req_stall carry one request per tick: req_op
// (tick, start reset, start byte write, start byte read), req_data_byte for
// a write and req_bus_level, the line level sampled on that tick. a command
// request is also the first tick of that command; commands that come while
// a command runs are taken as plain ticks.
// response channel: rsp_valid/rsp_stall return exactly one response per
// request: the drive for the line, busy and done flags, the last read byte
// and the missing presence flag.
// a request passes through an input register and the response register;
// one request per cycle is taken when the receiver does not stall.
// when rsp_stall is high the response holds and the input register fills,
// then req_stall rises until the response is taken.
// reset clears the bus phase, counters and flags, empties both registers
// and loads the default timing registers. csr_write loads a timing register.
module one_wire_bus_master #(
   parameter int COUNT_WIDTH = owbm_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_op,
   input  logic [7:0]                            req_data_byte,
   input  logic                                  req_bus_level,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_drive_low,
   output logic                                  rsp_busy_res,
   output logic                                  rsp_done_res,
   output logic [7:0]                            rsp_read_data,
   output logic                                  rsp_no_presence,
   input  logic                                  csr_write,
   input  logic [owbm_pkg::CFG_INDEX_WIDTH-1:0]  csr_index,
   input  logic [owbm_pkg::CFG_WIDTH-1:0]        csr_data
);

   owbm_pkg::cfg_type cfg_ff, cfg_in;
   owbm_pkg::req_type req_ff, req_in;
   owbm_pkg::rsp_type rsp_ff, rsp_in;
   logic              req_valid_ff, req_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept, advance;

   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      req_in       = accept ? owbm_pkg::req_type'{op: req_op, data_byte: req_data_byte,
                                                  bus_level: req_bus_level} : req_ff;
      req_valid_in = accept ? 1'b1 : (advance ? 1'b0 : req_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            owbm_pkg::REG_RESET_LOW:     cfg_in.reset_low_ticks      = csr_data;
            owbm_pkg::REG_PRESENCE_WAIT: cfg_in.presence_wait_ticks  = csr_data;
            owbm_pkg::REG_RESET_RECOVER: cfg_in.reset_recovery_ticks = csr_data;
            owbm_pkg::REG_WRITE_GAP:     cfg_in.write_gap_ticks      = csr_data;
            owbm_pkg::REG_WRITE_LOW:     cfg_in.write_low_ticks      = csr_data;
            owbm_pkg::REG_WRITE_SLOT:    cfg_in.write_slot_ticks     = csr_data;
            owbm_pkg::REG_READ_SAMPLE:   cfg_in.read_sample_ticks    = csr_data;
            owbm_pkg::REG_READ_TAIL:     cfg_in.read_tail_ticks      = csr_data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   owbm_engine #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .req     (req_ff),
      .cfg     (cfg_ff),
      .rsp     (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= owbm_pkg::CFG_DEFAULT;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_low   = rsp_ff.drive_low;
   assign rsp_busy_res    = rsp_ff.busy_res;
   assign rsp_done_res    = rsp_ff.done_res;
   assign rsp_read_data   = rsp_ff.read_data;
   assign rsp_no_presence = rsp_ff.no_presence;

endmodule

// ===== src/owbm_checker.sv =====
module owbm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_drive_low,
   input logic       rsp_busy_res,
   input logic       rsp_done_res,
   input logic [7:0] rsp_read_data,
   input logic       rsp_no_presence
);

   a_done_is_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_busy_res)
      else $error("done without busy");

   a_idle_released: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy_res |-> !rsp_drive_low)
      else $error("line driven while idle");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_data)
         && $stable(rsp_no_presence) && $stable(rsp_done_res))
      else $error("stalled response changed");

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (.*);
